// ===== rtl/lqtd_pkg.sv =====
// Shared types, widths and constants for the leaky quadrature tone detector.
// Holds the quarter-wave sine table builder and the controller command struct.
// No dependencies.
`default_nettype none

package lqtd_pkg;

  // Field widths.
  localparam int SAMPLE_W = 16;
  localparam int STEP_W   = 32;
  localparam int RETAIN_W = 16;
  localparam int MAG_W    = 40;
  localparam int TRIG_W   = 16;

  // Design sizes.
  localparam int ACC_W      = 40;
  localparam int PHASE_W    = 32;
  localparam int SINE_DEPTH = 1024;

  // Derived widths.
  localparam int IDX_W   = $clog2(SINE_DEPTH);
  localparam int DEPTH_W = $clog2(SINE_DEPTH + 1);
  localparam int FRAC_W  = PHASE_W - 2;
  localparam int IPROD_W = FRAC_W + DEPTH_W;
  localparam int TPROD_W = SAMPLE_W + TRIG_W;
  localparam int DPROD_W = ACC_W + RETAIN_W;
  localparam int HALF_W  = (ACC_W + 1) / 2;
  localparam int RT_W    = 2 * HALF_W;
  localparam int SQ_W    = 4 * HALF_W;
  localparam int REM_W   = RT_W + 3;
  localparam int CMP_W   = (RT_W > MAG_W) ? RT_W : MAG_W;

  // Sequencing counts.
  localparam int RT_STEPS = RT_W;
  localparam int CNT_W    = $clog2(RT_STEPS);
  localparam int SQ_TERMS = 3;
  localparam int SQ_STEPS = 2 * SQ_TERMS;

  // Constants.
  localparam logic [RETAIN_W-1:0] RETAIN_RESET = 16'd64596;
  localparam logic [TRIG_W-1:0]   TRIG_MAX     = 16'd32767;
  localparam logic [MAG_W-1:0]    MAG_MAX      = '1;
  localparam logic [PHASE_W-1:0]  QUARTER_TURN = {2'b01, {FRAC_W{1'b0}}};
  localparam logic [63:0]         HALF_PI_Q30  = 64'd1686629713;

  // Controller states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SIN,
    ST_COS,
    ST_ADD,
    ST_SQ,
    ST_SQ_LAST,
    ST_RT_INIT,
    ST_ROOT,
    ST_OUT
  } ctrl_state_t;

  // Partial product of a split square: high*high, high*low, low*low.
  typedef enum logic [1:0] {
    SQ_HH,
    SQ_HL,
    SQ_LL
  } sq_term_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     capture;
    logic     dec_mul;
    logic     dec_cos;
    logic     dec_wr;
    logic     rom_rd;
    logic     rom_cos;
    logic     trig_mul;
    logic     add_wr;
    logic     phase_adv;
    logic     sq_clear;
    logic     sq_mul;
    logic     sq_sin;
    sq_term_t sq_term;
    logic     sq_add;
    logic     rt_init;
    logic     rt_step;
    logic     out_load;
  } dp_cmd_t;

  typedef logic [SINE_DEPTH-1:0][TRIG_W-1:0] sine_rom_t;

  // One quarter-wave entry, sin(pi/2*k/D), by a truncating Taylor series in Q2.30.
  function automatic logic [TRIG_W-1:0] quarter_sine(input int unsigned k);
    logic [63:0] x;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] v;
    x = (HALF_PI_Q30 * 64'(k)) / 64'(SINE_DEPTH);
    s = x;
    t = x;
    for (int n = 1; n <= 6; n++) begin
      t = (((t * x) >> 30) * x) >> 30;
      case (n)
        1:       t = t / 64'd6;
        2:       t = t / 64'd20;
        3:       t = t / 64'd42;
        4:       t = t / 64'd72;
        5:       t = t / 64'd110;
        default: t = t / 64'd156;
      endcase
      if (n[0]) begin
        s = (t > s) ? 64'd0 : s - t;
      end else begin
        s = s + t;
      end
    end
    v = (s + 64'd16384) >> 15;
    return (v > 64'd32767) ? TRIG_MAX : TRIG_W'(v);
  endfunction

  // Whole quarter-wave table, built at elaboration.
  function automatic sine_rom_t build_sine_rom();
    sine_rom_t rom;
    for (int k = 0; k < SINE_DEPTH; k++) begin
      rom[k] = quarter_sine(k);
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

`default_nettype wire

// ===== rtl/leaky_quadrature_tone_detector.sv =====
// Leaky quadrature tone detector: single-bin DFT with exponential forgetting.
// Top level joining lqtd_ctrl and lqtd_datapath; uses lqtd_pkg.
//
// Usage:
// - Input channel (in_valid/in_stall): one audio sample (Q1.15) and a phase step
//   (turn fraction times 2^32) per transfer.
// - Result channel (out_valid/out_stall): one 40-bit magnitude per input item,
//   the hypotenuse of the two decayed accumulators, saturating at all ones.
// - cfg_wr_en/cfg_wr_data write the Q0.16 retain factor; write only while idle.
// - The square root produces one result bit per cycle and dominates; the rest
//   are the shared decay and trig multipliers, the single-port sine table and
//   six half-width partial products.
// - One item at a time: in_stall is high from the cycle after a transfer until
//   the result sits in the output register.
// - A stalled result waits in the output register; the next item is accepted
//   meanwhile and holds in its last step until that register is free.
// - Reset (rst_n low, synchronous) clears both accumulators and the phase,
//   sets the retain factor to 64596 and empties the output register.
`default_nettype none

module leaky_quadrature_tone_detector (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  cfg_wr_en,
  input  wire logic [lqtd_pkg::RETAIN_W-1:0]         cfg_wr_data,
  input  wire logic                                  in_valid,
  output logic                                       in_stall,
  input  wire logic signed [lqtd_pkg::SAMPLE_W-1:0]  in_sample,
  input  wire logic signed [lqtd_pkg::STEP_W-1:0]    in_phase_step,
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output logic [lqtd_pkg::MAG_W-1:0]                 out_magnitude
);

  lqtd_pkg::dp_cmd_t dp_cmd;

  // Sequencer.
  lqtd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (dp_cmd)
  );

  // Arithmetic and state.
  lqtd_datapath u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (dp_cmd),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_sample     (in_sample),
    .in_phase_step (in_phase_step),
    .out_magnitude (out_magnitude)
  );

  // An accepted item blocks the input in the following cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not blocked after a transfer");

  // Item registers are loaded only on an input transfer.
  assert property (@(posedge clk) disable iff (!rst_n)
    dp_cmd.capture |-> (in_valid && !in_stall))
    else $error("item captured without an input transfer");

  // A result is loaded only when the output register is free.
  assert property (@(posedge clk) disable iff (!rst_n)
    dp_cmd.out_load |-> (!out_valid || !out_stall))
    else $error("result loaded over a pending result");

  // A result appears only after a load.
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(dp_cmd.out_load))
    else $error("out_valid rose without a result load");

endmodule

`default_nettype wire

// ===== rtl/lqtd_ctrl.sv =====
// Sequencing controller for the leaky quadrature tone detector.
// Drives the datapath command struct and both handshakes; uses lqtd_pkg.
`default_nettype none

module lqtd_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output lqtd_pkg::dp_cmd_t      cmd
);

  lqtd_pkg::ctrl_state_t            state_r;
  lqtd_pkg::ctrl_state_t            state_nxt;
  logic [lqtd_pkg::CNT_W-1:0]       cnt_r;
  logic [lqtd_pkg::CNT_W-1:0]       cnt_nxt;
  logic                             out_valid_r;
  logic                             out_valid_nxt;
  logic                             in_xfer;
  logic                             out_free;

  // Input is taken only while idle; the output register is free when empty or draining.
  assign in_xfer  = (state_r == lqtd_pkg::ST_IDLE) && in_valid;
  assign out_free = !out_valid_r || !out_stall;

  // Next state and step counter.
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      lqtd_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = lqtd_pkg::ST_SIN;
        end
      end
      lqtd_pkg::ST_SIN: begin
        state_nxt = lqtd_pkg::ST_COS;
      end
      lqtd_pkg::ST_COS: begin
        state_nxt = lqtd_pkg::ST_ADD;
      end
      lqtd_pkg::ST_ADD: begin
        state_nxt = lqtd_pkg::ST_SQ;
        cnt_nxt   = '0;
      end
      lqtd_pkg::ST_SQ: begin
        if (cnt_r == lqtd_pkg::CNT_W'(lqtd_pkg::SQ_STEPS - 1)) begin
          state_nxt = lqtd_pkg::ST_SQ_LAST;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      lqtd_pkg::ST_SQ_LAST: begin
        state_nxt = lqtd_pkg::ST_RT_INIT;
      end
      lqtd_pkg::ST_RT_INIT: begin
        state_nxt = lqtd_pkg::ST_ROOT;
        cnt_nxt   = '0;
      end
      lqtd_pkg::ST_ROOT: begin
        if (cnt_r == lqtd_pkg::CNT_W'(lqtd_pkg::RT_STEPS - 1)) begin
          state_nxt = lqtd_pkg::ST_OUT;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      lqtd_pkg::ST_OUT: begin
        if (out_free) begin
          state_nxt = lqtd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = lqtd_pkg::ST_IDLE;
      end
    endcase
  end

  // Datapath commands per state.
  always_comb begin
    cmd = '0;
    unique case (state_r)
      lqtd_pkg::ST_IDLE: begin
        // Start the sine-side decay and the sine lookup in the transfer cycle.
        cmd.capture = in_xfer;
        cmd.dec_mul = in_xfer;
        cmd.rom_rd  = in_xfer;
      end
      lqtd_pkg::ST_SIN: begin
        cmd.dec_wr   = 1'b1;
        cmd.dec_mul  = 1'b1;
        cmd.dec_cos  = 1'b1;
        cmd.trig_mul = 1'b1;
        cmd.rom_rd   = 1'b1;
        cmd.rom_cos  = 1'b1;
      end
      lqtd_pkg::ST_COS: begin
        cmd.dec_wr   = 1'b1;
        cmd.trig_mul = 1'b1;
        cmd.add_wr   = 1'b1;
      end
      lqtd_pkg::ST_ADD: begin
        cmd.add_wr    = 1'b1;
        cmd.phase_adv = 1'b1;
        cmd.sq_clear  = 1'b1;
      end
      lqtd_pkg::ST_SQ: begin
        cmd.sq_mul = 1'b1;
        cmd.sq_add = (cnt_r != '0);
        cmd.sq_sin = (cnt_r >= lqtd_pkg::CNT_W'(lqtd_pkg::SQ_TERMS));
        unique case (cnt_r[2:0]) inside
          3'd0, 3'd3: cmd.sq_term = lqtd_pkg::SQ_HH;
          3'd1, 3'd4: cmd.sq_term = lqtd_pkg::SQ_HL;
          default:    cmd.sq_term = lqtd_pkg::SQ_LL;
        endcase
      end
      lqtd_pkg::ST_SQ_LAST: begin
        cmd.sq_add = 1'b1;
      end
      lqtd_pkg::ST_RT_INIT: begin
        cmd.rt_init = 1'b1;
      end
      lqtd_pkg::ST_ROOT: begin
        cmd.rt_step = 1'b1;
      end
      lqtd_pkg::ST_OUT: begin
        cmd.out_load = out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  // Output valid flag follows loads and completed transfers.
  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lqtd_pkg::ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != lqtd_pkg::ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

// ===== rtl/lqtd_datapath.sv =====
// Datapath of the leaky quadrature tone detector: decay, sine lookup, accumulate,
// split squaring and bit-serial square root. Uses lqtd_pkg; driven by lqtd_ctrl.
`default_nettype none

module lqtd_datapath (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire lqtd_pkg::dp_cmd_t                     cmd,
  input  wire logic                                  cfg_wr_en,
  input  wire logic [lqtd_pkg::RETAIN_W-1:0]         cfg_wr_data,
  input  wire logic signed [lqtd_pkg::SAMPLE_W-1:0]  in_sample,
  input  wire logic signed [lqtd_pkg::STEP_W-1:0]    in_phase_step,
  output logic [lqtd_pkg::MAG_W-1:0]                 out_magnitude
);

  localparam int ACC_W   = lqtd_pkg::ACC_W;
  localparam int HALF_W  = lqtd_pkg::HALF_W;
  localparam int RT_W    = lqtd_pkg::RT_W;
  localparam int SQ_W    = lqtd_pkg::SQ_W;
  localparam int REM_W   = lqtd_pkg::REM_W;
  localparam int PHASE_W = lqtd_pkg::PHASE_W;

  // Configuration and item registers.
  logic [lqtd_pkg::RETAIN_W-1:0]        retain_r;
  logic signed [lqtd_pkg::SAMPLE_W-1:0] sample_r;
  logic [lqtd_pkg::STEP_W-1:0]          step_r;

  // Detector state.
  logic signed [ACC_W-1:0]              acc_cos_r;
  logic signed [ACC_W-1:0]              acc_sin_r;
  logic signed [ACC_W-1:0]              acc_cos_nxt;
  logic signed [ACC_W-1:0]              acc_sin_nxt;
  logic [PHASE_W-1:0]                   phase_r;

  // Decay stage.
  logic signed [ACC_W-1:0]              dec_src;
  logic [ACC_W-1:0]                     dec_mag;
  logic [lqtd_pkg::DPROD_W-1:0]         dprod_r;
  logic                                 dneg_r;
  logic                                 dcos_r;
  logic [ACC_W-1:0]                     dec_val;
  logic signed [ACC_W-1:0]              dec_res;

  // Sine lookup.
  logic [PHASE_W-1:0]                   look_phase;
  logic [1:0]                           look_quad;
  logic [lqtd_pkg::FRAC_W-1:0]          look_frac;
  logic [lqtd_pkg::IPROD_W-1:0]         idx_prod;
  logic [lqtd_pkg::IDX_W-1:0]           look_idx;
  logic [lqtd_pkg::IDX_W-1:0]           look_addr;
  logic [lqtd_pkg::TRIG_W-1:0]          rom_q_r;
  logic                                 rom_max_r;
  logic                                 rom_neg_r;
  logic                                 rom_cos_r;

  // Sample times trig and saturating add.
  logic [lqtd_pkg::TRIG_W-1:0]          trig_mag;
  logic signed [lqtd_pkg::TRIG_W-1:0]   trig_val;
  logic signed [lqtd_pkg::TPROD_W-1:0]  tprod_r;
  logic                                 tcos_r;
  logic signed [ACC_W-1:0]              add_dst;
  logic signed [ACC_W:0]                add_sum;
  logic signed [ACC_W-1:0]              add_res;

  // Split squaring.
  logic signed [ACC_W-1:0]              sq_src;
  logic [ACC_W-1:0]                     sq_mag;
  logic [RT_W-1:0]                      sq_ext;
  logic [HALF_W-1:0]                    sq_a;
  logic [HALF_W-1:0]                    sq_b;
  logic [RT_W-1:0]                      sprod_r;
  lqtd_pkg::sq_term_t                   sterm_r;
  logic [SQ_W-1:0]                      sq_term_val;
  logic [SQ_W-1:0]                      sq_r;

  // Square root.
  logic [SQ_W-1:0]                      rad_r;
  logic [REM_W-1:0]                     rem_r;
  logic [RT_W-1:0]                      root_r;
  logic [REM_W-1:0]                     rt_cand;
  logic [REM_W-1:0]                     rt_trial;
  logic                                 rt_ge;
  logic [lqtd_pkg::MAG_W-1:0]           out_magnitude_r;

  // Magnitude times retain, truncated, with the sign put back.
  assign dec_src = cmd.dec_cos ? acc_cos_r : acc_sin_r;
  assign dec_mag = dec_src[ACC_W-1] ? ACC_W'(-dec_src) : ACC_W'(dec_src);
  assign dec_val = dprod_r[lqtd_pkg::RETAIN_W +: ACC_W];
  assign dec_res = dneg_r ? -$signed(dec_val) : $signed(dec_val);

  always_ff @(posedge clk) begin
    if (cmd.dec_mul) begin
      dprod_r <= lqtd_pkg::DPROD_W'(dec_mag) * lqtd_pkg::DPROD_W'(retain_r);
      dneg_r  <= dec_src[ACC_W-1];
      dcos_r  <= cmd.dec_cos;
    end
  end

  // Table index from the phase, mirrored in odd quadrants.
  assign look_phase = phase_r + (cmd.rom_cos ? lqtd_pkg::QUARTER_TURN : '0);
  assign look_quad  = look_phase[PHASE_W-1 -: 2];
  assign look_frac  = look_phase[lqtd_pkg::FRAC_W-1:0];
  assign idx_prod   = lqtd_pkg::IPROD_W'(look_frac) *
                      lqtd_pkg::IPROD_W'(lqtd_pkg::SINE_DEPTH);
  assign look_idx   = lqtd_pkg::IDX_W'(idx_prod >> lqtd_pkg::FRAC_W);
  assign look_addr  = look_quad[0] ?
                      lqtd_pkg::IDX_W'(lqtd_pkg::DEPTH_W'(lqtd_pkg::SINE_DEPTH) -
                                       lqtd_pkg::DEPTH_W'(look_idx)) :
                      look_idx;

  // Quarter-wave table read, registered.
  always_ff @(posedge clk) begin
    if (cmd.rom_rd) begin
      rom_q_r   <= lqtd_pkg::SINE_ROM[look_addr];
      rom_max_r <= look_quad[0] && (look_idx == '0);
      rom_neg_r <= look_quad[1];
      rom_cos_r <= cmd.rom_cos;
    end
  end

  // Signed trig value; the top of an odd quadrant is full scale.
  assign trig_mag = rom_max_r ? lqtd_pkg::TRIG_MAX : rom_q_r;
  assign trig_val = rom_neg_r ? -$signed(trig_mag) : $signed(trig_mag);

  always_ff @(posedge clk) begin
    if (cmd.trig_mul) begin
      tprod_r <= sample_r * trig_val;
      tcos_r  <= rom_cos_r;
    end
  end

  // Saturating accumulate of the Q2.30 product.
  assign add_dst = tcos_r ? acc_cos_r : acc_sin_r;
  assign add_sum = $signed({add_dst[ACC_W-1], add_dst}) + (ACC_W + 1)'(tprod_r);
  always_comb begin
    if (add_sum[ACC_W] != add_sum[ACC_W-1]) begin
      add_res = add_sum[ACC_W] ? $signed({1'b1, {(ACC_W - 1){1'b0}}}) :
                                 $signed({1'b0, {(ACC_W - 1){1'b1}}});
    end else begin
      add_res = add_sum[ACC_W-1:0];
    end
  end

  // Accumulator updates; decay and add never target the same one in a cycle.
  always_comb begin
    acc_cos_nxt = acc_cos_r;
    acc_sin_nxt = acc_sin_r;
    if (cmd.dec_wr) begin
      if (dcos_r) begin
        acc_cos_nxt = dec_res;
      end else begin
        acc_sin_nxt = dec_res;
      end
    end
    if (cmd.add_wr) begin
      if (tcos_r) begin
        acc_cos_nxt = add_res;
      end else begin
        acc_sin_nxt = add_res;
      end
    end
  end

  // Detector state and configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      retain_r  <= lqtd_pkg::RETAIN_RESET;
      acc_cos_r <= '0;
      acc_sin_r <= '0;
      phase_r   <= '0;
    end else begin
      if (cfg_wr_en) begin
        retain_r <= cfg_wr_data;
      end
      acc_cos_r <= acc_cos_nxt;
      acc_sin_r <= acc_sin_nxt;
      if (cmd.phase_adv) begin
        phase_r <= phase_r + step_r[lqtd_pkg::STEP_W-1 -: PHASE_W];
      end
    end
  end

  // Item capture at the input transfer.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      sample_r <= in_sample;
      step_r   <= in_phase_step;
    end
  end

  // Square of each magnitude from three half-width partial products.
  assign sq_src = cmd.sq_sin ? acc_sin_r : acc_cos_r;
  assign sq_mag = sq_src[ACC_W-1] ? ACC_W'(-sq_src) : ACC_W'(sq_src);
  assign sq_ext = RT_W'(sq_mag);

  always_comb begin
    case (cmd.sq_term)
      lqtd_pkg::SQ_HH: begin
        sq_a = sq_ext[RT_W-1:HALF_W];
        sq_b = sq_ext[RT_W-1:HALF_W];
      end
      lqtd_pkg::SQ_HL: begin
        sq_a = sq_ext[RT_W-1:HALF_W];
        sq_b = sq_ext[HALF_W-1:0];
      end
      default: begin
        sq_a = sq_ext[HALF_W-1:0];
        sq_b = sq_ext[HALF_W-1:0];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.sq_mul) begin
      sprod_r <= RT_W'(sq_a) * RT_W'(sq_b);
      sterm_r <= cmd.sq_term;
    end
  end

  // Weight of the registered partial product; the cross term counts twice.
  always_comb begin
    case (sterm_r)
      lqtd_pkg::SQ_HH: sq_term_val = SQ_W'(sprod_r) << (2 * HALF_W);
      lqtd_pkg::SQ_HL: sq_term_val = SQ_W'(sprod_r) << (HALF_W + 1);
      default:         sq_term_val = SQ_W'(sprod_r);
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.sq_clear) begin
      sq_r <= '0;
    end else if (cmd.sq_add) begin
      sq_r <= sq_r + sq_term_val;
    end
  end

  // Restoring square root, one result bit per cycle.
  assign rt_cand  = {rem_r[REM_W-3:0], rad_r[SQ_W-1 -: 2]};
  assign rt_trial = REM_W'({root_r, 2'b01});
  assign rt_ge    = (rt_cand >= rt_trial);

  always_ff @(posedge clk) begin
    if (cmd.rt_init) begin
      rad_r  <= sq_r;
      rem_r  <= '0;
      root_r <= '0;
    end else if (cmd.rt_step) begin
      rad_r  <= rad_r << 2;
      rem_r  <= rt_ge ? (rt_cand - rt_trial) : rt_cand;
      root_r <= {root_r[RT_W-2:0], rt_ge};
    end
  end

  // Output register, saturated to the magnitude field.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_magnitude_r <= (lqtd_pkg::CMP_W'(root_r) > lqtd_pkg::CMP_W'(lqtd_pkg::MAG_MAX)) ?
                         lqtd_pkg::MAG_MAX : lqtd_pkg::MAG_W'(root_r);
    end
  end

  assign out_magnitude = out_magnitude_r;

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
// Self-checking testbench for the leaky quadrature tone detector.
// A scoreboard class predicts every magnitude and checks it, and plain tasks drive the block.
// Depends on lqtd_pkg and leaky_quadrature_tone_detector.

module testbench;
  import lqtd_pkg::*;

  localparam int SETTLE_CYCLES = 60;
  localparam int STALL_LIMIT   = 2000;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

  // Predicts the magnitude for each sample transfer and queues it for the result side.
  class magnitude_tracker;
    logic [TRIG_W-1:0]   quarter_wave [SINE_DEPTH];
    logic [RETAIN_W-1:0] retain;
    longint              acc_cos;
    longint              acc_sin;
    logic [PHASE_W-1:0]  phase;
    logic [MAG_W-1:0]    pending_mags [$];
    int unsigned         failures;

    function new();
      for (int k = 0; k < SINE_DEPTH; k++) begin
        quarter_wave[k] = series_entry(k);
      end
      retain   = RETAIN_RESET;
      acc_cos  = 0;
      acc_sin  = 0;
      phase    = '0;
      failures = 0;
    endfunction

    // Truncating Taylor series of sin(pi/2*k/D) in Q2.30, rounded to Q1.15.
    function logic [TRIG_W-1:0] series_entry(int unsigned k);
      logic [63:0] x;
      logic [63:0] term;
      logic [63:0] total;
      logic [63:0] rounded;
      x = (HALF_PI_Q30 * 64'(k)) / 64'(SINE_DEPTH);
      total = x;
      term = x;
      for (int n = 1; n <= 6; n++) begin
        term = (((term * x) >> 30) * x) >> 30;
        term = term / 64'((2 * n) * (2 * n + 1));
        if (n % 2 == 1) begin
          total = (term > total) ? 64'd0 : total - term;
        end else begin
          total = total + term;
        end
      end
      rounded = (total + 64'd16384) >> 15;
      return (rounded > 64'd32767) ? TRIG_MAX : rounded[TRIG_W-1:0];
    endfunction

    // Full-wave sine from the quarter table; quadrant from the top two phase bits.
    function logic signed [TRIG_W-1:0] trig_at(logic [PHASE_W-1:0] p);
      logic [1:0]        quad;
      logic [63:0]       idx;
      logic [TRIG_W-1:0] mag;
      quad = p[PHASE_W-1 -: 2];
      idx = (64'(p[FRAC_W-1:0]) * 64'(SINE_DEPTH)) >> FRAC_W;
      if (idx >= SINE_DEPTH) begin
        idx = SINE_DEPTH - 1;
      end
      if (quad[0]) begin
        mag = (idx == 0) ? TRIG_MAX : quarter_wave[SINE_DEPTH - idx];
      end else begin
        mag = quarter_wave[idx];
      end
      return quad[1] ? -$signed(mag) : $signed(mag);
    endfunction

    // Decay toward zero: the magnitude is scaled by retain/2^16 and truncated.
    function longint shrink(longint acc);
      longint unsigned m;
      longint unsigned d;
      m = (acc < 0) ? longint'(-acc) : acc;
      d = (m >> 16) * retain + (((m & 64'hFFFF) * retain) >> 16);
      return (acc < 0) ? -longint'(d) : longint'(d);
    endfunction

    function longint clamp_acc(longint s);
      longint hi;
      longint lo;
      hi = (longint'(1) << (ACC_W - 1)) - 1;
      lo = -hi - 1;
      if (s > hi) return hi;
      if (s < lo) return lo;
      return s;
    endfunction

    // Floor of the hypotenuse, one result bit per pass.
    function logic [MAG_W-1:0] root_magnitude();
      longint unsigned ax;
      longint unsigned ay;
      longint unsigned r;
      longint unsigned c;
      logic [127:0]    norm;
      logic [127:0]    csq;
      ax = (acc_cos < 0) ? longint'(-acc_cos) : acc_cos;
      ay = (acc_sin < 0) ? longint'(-acc_sin) : acc_sin;
      norm = 128'(ax) * 128'(ax) + 128'(ay) * 128'(ay);
      r = 0;
      for (int b = 41; b >= 0; b--) begin
        c = r | (64'd1 << b);
        csq = 128'(c) * 128'(c);
        if (csq <= norm) begin
          r = c;
        end
      end
      return (r > MAG_MAX) ? MAG_MAX : r[MAG_W-1:0];
    endfunction

    // Called on each accepted input transfer.
    function void take_sample(logic signed [SAMPLE_W-1:0] smp, logic [STEP_W-1:0] stp);
      logic signed [TRIG_W-1:0] s_trig;
      logic signed [TRIG_W-1:0] c_trig;
      acc_cos = shrink(acc_cos);
      acc_sin = shrink(acc_sin);
      s_trig = trig_at(phase);
      c_trig = trig_at(phase + QUARTER_TURN);
      acc_cos = clamp_acc(acc_cos + longint'(smp) * longint'(c_trig));
      acc_sin = clamp_acc(acc_sin + longint'(smp) * longint'(s_trig));
      phase = phase + PHASE_W'(stp >> (STEP_W - PHASE_W));
      pending_mags.push_back(root_magnitude());
    endfunction

    function void report(string what, logic [MAG_W-1:0] want, logic [MAG_W-1:0] got);
      failures++;
      if (failures <= 10) begin
        $display("%s: expected %0d, got %0d", what, want, got);
      end
    endfunction

    // Called on each accepted result transfer.
    function void check_magnitude(logic [MAG_W-1:0] got);
      logic [MAG_W-1:0] want;
      if (pending_mags.size() == 0) begin
        report("magnitude with no sample outstanding", '0, got);
        return;
      end
      want = pending_mags.pop_front();
      if (got !== want) begin
        report("magnitude mismatch", want, got);
      end
    endfunction
  endclass

  logic                       clk           = 1'b0;
  logic                       rst_n         = 1'b0;
  logic                       cfg_wr_en     = 1'b0;
  logic [RETAIN_W-1:0]        cfg_wr_data   = '0;
  logic                       in_valid      = 1'b0;
  logic signed [SAMPLE_W-1:0] in_sample     = '0;
  logic signed [STEP_W-1:0]   in_phase_step = '0;
  logic                       out_stall     = 1'b0;
  logic                       in_stall;
  logic                       out_valid;
  logic [MAG_W-1:0]           out_magnitude;

  // Set during stretches in which neither side idles.
  logic             calm = 1'b0;
  int               idle_cycles = 0;
  int               out_hold = 0;
  magnitude_tracker tracker;

  always #5 clk = ~clk;

  leaky_quadrature_tone_detector uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_sample     (in_sample),
    .in_phase_step (in_phase_step),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_magnitude (out_magnitude)
  );

  // Result side: check each transfer, then stall a random number of valid cycles.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      out_hold = 0;
    end else begin
      if (out_valid && !out_stall) begin
        tracker.check_magnitude(out_magnitude);
        out_hold = calm ? 0 : $urandom_range(0, 9);
      end else if (out_valid && out_hold > 0) begin
        out_hold--;
      end
      out_stall <= (out_hold != 0);
    end
  end

  // Watchdog: too long without any transfer ends the run.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // Offer one sample after a random gap and return at the edge of its transfer.
  task automatic push_sample(input logic signed [SAMPLE_W-1:0] smp,
                             input logic [STEP_W-1:0] stp);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_sample     <= smp;
    in_phase_step <= stp;
    do @(posedge clk); while (in_stall);
    tracker.take_sample(smp, stp);
  endtask

  // Hold off the sender until every queued magnitude has arrived and the block is idle.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (tracker.pending_mags.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_retain_factor(input logic [RETAIN_W-1:0] value);
    drain_results();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    tracker.retain = value;
  endtask

  // Mostly runs of a tone against a fixed probe step, with noise and broken runs mixed in.
  task automatic play_random(input int total);
    int              sent;
    int              len;
    int              kind;
    int              amp;
    longint          level;
    logic [STEP_W-1:0]  probe;
    logic [STEP_W-1:0]  tone_step;
    logic [PHASE_W-1:0] tone_phase;
    sent = 0;
    while (sent < total) begin
      calm = ($urandom_range(0, 3) == 0);
      kind = $urandom_range(0, 3);
      len = $urandom_range(8, 40);
      if (len > total - sent) begin
        len = total - sent;
      end
      probe = ($urandom_range(0, 2) == 0) ? $urandom() : $urandom_range(0, 32'h0400_0000);
      if ($urandom_range(0, 1) == 1) begin
        probe = -probe;
      end
      tone_step = probe + $urandom_range(0, 4000) - 2000;
      tone_phase = $urandom();
      amp = $urandom_range(0, 32767);
      for (int i = 0; i < len; i++) begin
        if (kind == 0) begin
          push_sample(16'($urandom()), $urandom());
        end else begin
          level = (longint'(amp) * longint'(tracker.trig_at(tone_phase))) >>> 15;
          level = level + longint'($urandom_range(0, 256)) - 128;
          if (level > 32767) level = 32767;
          if (level < -32768) level = -32768;
          tone_phase = tone_phase + tone_step;
          push_sample(16'(level), ($urandom_range(0, 19) == 0) ? $urandom() : probe);
        end
      end
      sent += len;
    end
    calm = 1'b0;
  endtask

  initial begin
    logic [RETAIN_W-1:0] plan [5];
    tracker = new();
    plan = '{RETAIN_RESET, 16'($urandom_range(1, 65534)), 16'd1, 16'hFFFF,
             16'($urandom_range(60000, 65534))};
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Field extremes, quarter and half turns, and backward phase steps at the reset factor.
    push_sample(SAMPLE_MAX, 32'h0000_0000);
    push_sample(SAMPLE_MIN, 32'h0000_0000);
    push_sample(16'sd0, 32'h4000_0000);
    push_sample(SAMPLE_MAX, 32'h4000_0000);
    push_sample(SAMPLE_MIN, 32'h8000_0000);
    push_sample(SAMPLE_MAX, 32'h7FFF_FFFF);
    push_sample(-16'sd1, 32'hFFFF_FFFF);
    push_sample(16'sd1, 32'hC000_0000);
    push_sample(16'sh5555, 32'h5555_5555);
    push_sample(16'shAAAA, 32'hAAAA_AAAA);
    push_sample(SAMPLE_MAX, 32'h0010_0000);
    push_sample(SAMPLE_MIN, 32'hFFF0_0000);
    push_sample(SAMPLE_MAX, 32'h8000_0000);
    push_sample(SAMPLE_MIN, 32'h8000_0000);

    // Zero retain: only the current products survive.
    set_retain_factor(16'd0);
    push_sample(SAMPLE_MAX, 32'h1234_5678);
    push_sample(SAMPLE_MIN, 32'h8765_4321);
    push_sample(16'sd0, 32'h0000_0000);
    push_sample(16'sd12345, 32'h4000_0000);

    // Almost no decay and a steady full-scale input at phase zero drive the
    // cosine accumulator into saturation.
    set_retain_factor(16'hFFFF);
    push_sample(SAMPLE_MAX, -tracker.phase);
    for (int i = 0; i < 539; i++) begin
      push_sample(SAMPLE_MAX, 32'h0000_0000);
    end

    foreach (plan[p]) begin
      set_retain_factor(plan[p]);
      play_random(150);
    end

    drain_results();
    if (tracker.failures == 0 && tracker.pending_mags.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/lqtd_pkg.sv
rtl/lqtd_ctrl.sv
rtl/lqtd_datapath.sv
rtl/leaky_quadrature_tone_detector.sv
dv/testbench.sv
